/* hw/rtl/elfo_pkg.sv */
package elfo_pkg;

    // sine table size, any value from 64 to 65536
    localparam int unsigned SINE_TABLE_ENTRIES = 1024;
    localparam int unsigned SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES);

    // fade divider: one quotient bit per stage
    localparam int unsigned DIV_STEPS = 16;

    localparam logic [16:0] Q16_ONE = 17'h10000;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    typedef enum logic [2:0] {
        REG_LIFE_TIME       = 3'd0,
        REG_START_DELAY     = 3'd1,
        REG_FADE_OUT_LENGTH = 3'd2,
        REG_PULSE_MODE      = 3'd3,
        REG_PULSE_FREQ      = 3'd4,
        REG_PULSE_PHASE     = 3'd5,
        REG_PULSE_AMPLITUDE = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        MODE_NONE      = 3'd0,
        MODE_SINE      = 3'd1,
        MODE_RAMP_UP   = 3'd2,
        MODE_RAMP_DOWN = 3'd3,
        MODE_TRIANGLE  = 3'd4,
        MODE_SQUARE25  = 3'd5,
        MODE_SQUARE50  = 3'd6,
        MODE_SQUARE75  = 3'd7
    } t_pulse_mode;

    typedef logic [16:0] t_sine_rom [SINE_TABLE_ENTRIES];

    // one table entry, 0.5 + 0.5 sin in q1.16, from a q30 taylor series
    function automatic logic [16:0] sine_entry(input logic [31:0] k);
        logic [63:0] f;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] half;
        logic [1:0]  q;
        f  = ({32'd0, k} << 32) / SINE_TABLE_ENTRIES;
        q  = f[31:30];
        r  = f & (Q30_ONE - 64'd1);
        if (q[0]) begin
            r = Q30_ONE - r;
        end
        x  = (r * Q30_HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        half = (s + 64'd16384) >> 15;
        if (half > 64'd32768) begin
            half = 64'd32768;
        end
        if (q[1]) begin
            return 17'(64'd32768 - half);
        end
        return 17'(64'd32768 + half);
    endfunction

    function automatic t_sine_rom sine_rom_image();
        t_sine_rom img;
        for (int unsigned i = 0; i < SINE_TABLE_ENTRIES; i++) begin
            img[i] = sine_entry(32'(i));
        end
        return img;
    endfunction

endpackage

/* hw/rtl/elfo_sine_rom.sv */
module elfo_sine_rom (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [elfo_pkg::SINE_IDX_W-1:0] i_idx,
    output logic [16:0]                     o_data
);

    localparam elfo_pkg::t_sine_rom SINE_ROM = elfo_pkg::sine_rom_image();

    logic [16:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_ROM[i_idx];
        end
    end

    assign o_data = r_data;

endmodule

/* hw/rtl/elfo_fade_div.sv */
module elfo_fade_div (
    input  logic                           i_clk,
    input  logic [elfo_pkg::DIV_STEPS-1:0] i_en,
    input  logic [31:0]                    i_rem,
    input  logic [31:0]                    i_div,
    output logic [elfo_pkg::DIV_STEPS-1:0] o_quo
);

    localparam int unsigned N = elfo_pkg::DIV_STEPS;

    // remainder stays below the divisor, so each step is one compare and subtract
    logic [31:0]  r_rem [N];
    logic [N-1:0] r_quo [N];
    logic [31:0]  n_rem [N];
    logic [N-1:0] n_quo [N];

    always_comb begin
        logic [32:0] sh;
        logic [31:0] rem_in;
        logic [N-1:0] quo_in;
        for (int i = 0; i < N; i++) begin
            rem_in = (i == 0) ? i_rem : r_rem[(i == 0) ? 0 : i - 1];
            quo_in = (i == 0) ? '0 : r_quo[(i == 0) ? 0 : i - 1];
            sh = {rem_in, 1'b0};
            if (sh >= {1'b0, i_div}) begin
                n_rem[i] = 32'(sh - {1'b0, i_div});
                n_quo[i] = {quo_in[N-2:0], 1'b1};
            end else begin
                n_rem[i] = sh[31:0];
                n_quo[i] = {quo_in[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            if (i_en[i]) begin
                r_rem[i] <= n_rem[i];
                r_quo[i] <= n_quo[i];
            end
        end
    end

    assign o_quo = r_quo[N-1];

endmodule

/* hw/rtl/envelope_and_lfo_generator.sv */
// Envelope and LFO generator. Each transfer on the input carries one absolute time
// (unsigned q16.16 seconds) and yields one result transfer with the envelope intensity
// and the pulse level, both unsigned q1.16 (65536 is 1.0). The block is a 19-stage
// pipeline: it takes one item every cycle while the output is not stalled; its depth
// is set by the 16-step divider of the fade-out ramp, one quotient bit per stage.
// Every stage holds its item until the next one has room, so bubbles close up under
// a stalled output and the input keeps taking items while results wait, until every
// stage is full. Registers are written through the cfg port (always ready) and are
// meant to change only while the pipeline is empty. Index 0 life_time, 1 start_delay,
// 2 fade_out_length, 3 pulse_mode, 4 pulse_freq, 5 pulse_phase, 6 pulse_amplitude;
// index 7 is ignored.
module envelope_and_lfo_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // time samples in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_current_time,

    // results out
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_intensity,
    output logic [16:0] o_pulse_level,

    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned DIV_N  = elfo_pkg::DIV_STEPS;
    localparam int unsigned ST_DIV = 3;              // first divider stage
    localparam int unsigned NS     = DIV_N + 3;      // last stage drives the outputs

    typedef enum logic [1:0] {
        ENV_ONE,
        ENV_ZERO,
        ENV_FADE
    } t_env;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_life_time;
    logic [31:0] r_start_delay;
    logic [31:0] r_fade_len;
    logic [2:0]  r_pulse_mode;
    logic [23:0] r_pulse_freq;
    logic [15:0] r_pulse_phase;
    logic [16:0] r_pulse_amp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life_time   <= '0;
            r_start_delay <= '0;
            r_fade_len    <= '0;
            r_pulse_mode  <= elfo_pkg::MODE_NONE;
            r_pulse_freq  <= 24'h010000;
            r_pulse_phase <= '0;
            r_pulse_amp   <= elfo_pkg::Q16_ONE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                elfo_pkg::REG_LIFE_TIME:       r_life_time   <= i_cfg_data;
                elfo_pkg::REG_START_DELAY:     r_start_delay <= i_cfg_data;
                elfo_pkg::REG_FADE_OUT_LENGTH: r_fade_len    <= i_cfg_data;
                elfo_pkg::REG_PULSE_MODE:      r_pulse_mode  <= i_cfg_data[2:0];
                elfo_pkg::REG_PULSE_FREQ:      r_pulse_freq  <= i_cfg_data[23:0];
                elfo_pkg::REG_PULSE_PHASE:     r_pulse_phase <= i_cfg_data[15:0];
                elfo_pkg::REG_PULSE_AMPLITUDE: r_pulse_amp   <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // amplitude above 1.0 saturates
    logic [16:0] amp_sat;
    assign amp_sat = (r_pulse_amp > elfo_pkg::Q16_ONE) ? elfo_pkg::Q16_ONE : r_pulse_amp;

    // ------------------------------------------------------------------
    // stage valids and per-stage advance
    // ------------------------------------------------------------------
    // a stage advances when it is empty or the stage after it advances
    logic [NS:1] r_v;
    logic [NS:1] stg_en;

    always_comb begin
        stg_en[NS] = !r_v[NS] || !i_stall;
        for (int k = NS - 1; k >= 1; k--) begin
            stg_en[k] = !r_v[k] || stg_en[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (stg_en[k]) begin
                    r_v[k] <= r_v[k - 1];
                end
            end
        end
    end

    assign o_stall = !stg_en[1];
    assign o_valid = r_v[NS];

    // ------------------------------------------------------------------
    // stage 1: time relative to the start delay
    // ------------------------------------------------------------------
    logic        r_early;    // sample before the start delay
    logic [31:0] r_u;        // time since start, wraps when early
    logic [31:0] r_t;        // pulse time, held at zero when early

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_early <= i_current_time < r_start_delay;
            r_u     <= i_current_time - r_start_delay;
            r_t     <= (i_current_time > r_start_delay) ?
                       (i_current_time - r_start_delay) : 32'd0;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: envelope region, fade offset, phase product
    // ------------------------------------------------------------------
    t_env        r_env [2:NS-1];
    logic [31:0] r_fade_d;       // time into the fade window, below fade length
    logic [15:0] r_phase_acc;    // fractional cycles of t * freq
    t_env        n_env;
    logic [32:0] u_plus_fade;
    logic [55:0] t_freq;

    assign u_plus_fade = {1'b0, r_u} + {1'b0, r_fade_len};
    assign t_freq      = r_t * r_pulse_freq;

    always_comb begin
        if (r_life_time == 32'd0) begin
            n_env = ENV_ONE;
        end else if (r_early || (r_u >= r_life_time)) begin
            n_env = ENV_ZERO;
        end else if (u_plus_fade > {1'b0, r_life_time}) begin
            // inside the final fade window; cannot happen with a zero window
            n_env = ENV_FADE;
        end else begin
            n_env = ENV_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_fade_d    <= 32'(u_plus_fade - {1'b0, r_life_time});
            r_phase_acc <= t_freq[31:16];
        end
    end

    // envelope region rides along the divider stages
    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_env[2] <= n_env;
        end
        for (int k = 3; k <= NS - 1; k++) begin
            if (stg_en[k]) begin
                r_env[k] <= r_env[k - 1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 3 to 18: fade ramp, floor(d * 65536 / fade_out_length)
    // ------------------------------------------------------------------
    logic [DIV_N-1:0] fade_quo;

    elfo_fade_div u_fade_div (
        .i_clk (i_clk),
        .i_en  (stg_en[ST_DIV +: DIV_N]),
        .i_rem (r_fade_d),
        .i_div (r_fade_len),
        .o_quo (fade_quo)
    );

    // ------------------------------------------------------------------
    // stage 3: phase and sine index
    // ------------------------------------------------------------------
    logic [15:0]                     r_p;
    logic [elfo_pkg::SINE_IDX_W-1:0] r_sine_idx;
    logic [15:0]                     phase;
    logic [32:0]                     idx_prod;

    assign phase    = r_phase_acc + r_pulse_phase;
    assign idx_prod = {17'd0, phase} * 33'(elfo_pkg::SINE_TABLE_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_p        <= phase;
            r_sine_idx <= idx_prod[16 +: elfo_pkg::SINE_IDX_W];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: sine lookup and the other wave shapes
    // ------------------------------------------------------------------
    logic [16:0] sine_val;
    logic [16:0] r_wave_lin;
    logic [16:0] n_wave_lin;
    logic [16:0] p_ext;

    elfo_sine_rom u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (stg_en[4]),
        .i_idx  (r_sine_idx),
        .o_data (sine_val)
    );

    assign p_ext = {1'b0, r_p};

    always_comb begin
        case (r_pulse_mode)
            elfo_pkg::MODE_RAMP_UP:   n_wave_lin = p_ext;
            elfo_pkg::MODE_RAMP_DOWN: n_wave_lin = elfo_pkg::Q16_ONE - p_ext;
            elfo_pkg::MODE_TRIANGLE:
                n_wave_lin = (r_p <= 16'h8000) ? {r_p, 1'b0} :
                             17'((elfo_pkg::Q16_ONE - p_ext) << 1);
            elfo_pkg::MODE_SQUARE25:
                n_wave_lin = (r_p < 16'h4000) ? elfo_pkg::Q16_ONE : 17'd0;
            elfo_pkg::MODE_SQUARE50:
                n_wave_lin = (r_p < 16'h8000) ? elfo_pkg::Q16_ONE : 17'd0;
            elfo_pkg::MODE_SQUARE75:
                n_wave_lin = (r_p < 16'hC000) ? elfo_pkg::Q16_ONE : 17'd0;
            default: n_wave_lin = 17'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_wave_lin <= n_wave_lin;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: wave times amplitude
    // ------------------------------------------------------------------
    logic [16:0] wave;
    logic [33:0] wave_amp;
    logic [16:0] r_wave_amp;

    assign wave     = (r_pulse_mode == elfo_pkg::MODE_SINE) ? sine_val : r_wave_lin;
    assign wave_amp = wave * amp_sat;

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r_wave_amp <= wave_amp[32:16];
        end
    end

    // ------------------------------------------------------------------
    // stage 6: blend toward 1.0, then delay to line up with the envelope
    // ------------------------------------------------------------------
    logic [16:0] r_pulse [6:NS];

    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r_pulse[6] <= (r_pulse_mode == elfo_pkg::MODE_NONE) ? elfo_pkg::Q16_ONE :
                          r_wave_amp + (elfo_pkg::Q16_ONE - amp_sat);
        end
        for (int k = 7; k <= NS; k++) begin
            if (stg_en[k]) begin
                r_pulse[k] <= r_pulse[k - 1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 19: output register
    // ------------------------------------------------------------------
    logic [16:0] r_intensity;

    always_ff @(posedge i_clk) begin
        if (stg_en[NS]) begin
            case (r_env[NS-1])
                ENV_ONE:  r_intensity <= elfo_pkg::Q16_ONE;
                ENV_ZERO: r_intensity <= 17'd0;
                ENV_FADE: r_intensity <= elfo_pkg::Q16_ONE - {1'b0, fade_quo};
                default:  r_intensity <= 17'd0;
            endcase
        end
    end

    assign o_intensity   = r_intensity;
    assign o_pulse_level = r_pulse[NS];

endmodule
